/* src/vspc_pkg.sv */
// Shared constants, register indexes and handshake structs for the VGA pixel capture block.
`timescale 1ns / 1ps

package vspc_pkg;

  localparam int CoordBits = 10;
  localparam int ModBits   = CoordBits + 1;
  localparam int ColorBits = 4;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = ModBits;
  localparam int RemCntBits  = $clog2(ModBits + 1);

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegActiveWidth   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegTotalWidth    = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegHResyncOffset = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegActiveHeight  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegTotalHeight   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegVResyncOffset = 3'd5;

  // register reset values
  localparam int ActiveWidthReset   = 640;
  localparam int TotalWidthReset    = 800;
  localparam int HResyncOffsetReset = 144;
  localparam int ActiveHeightReset  = 480;
  localparam int TotalHeightReset   = 521;
  localparam int VResyncOffsetReset = 31;

  // precomputed advance values that match the reset configuration
  localparam int CoordMod = 1 << CoordBits;
  localparam int ColAdvReset = (1 % TotalWidthReset) % CoordMod;
  localparam int RowAdvReset = (1 % TotalHeightReset) % CoordMod;
  localparam int HReloadReset = (TotalWidthReset - HResyncOffsetReset) % CoordMod;
  localparam int VReloadReset = (TotalHeightReset - VResyncOffsetReset) % CoordMod;
  localparam int HReloadAdvReset = ((HReloadReset + 1) % TotalWidthReset) % CoordMod;
  localparam int VReloadAdvReset = ((VReloadReset + 1) % TotalHeightReset) % CoordMod;

  // remainder recompute jobs
  localparam logic [1:0] JobColAdv     = 2'd0;
  localparam logic [1:0] JobHReloadAdv = 2'd1;
  localparam logic [1:0] JobRowAdv     = 2'd2;
  localparam logic [1:0] JobVReloadAdv = 2'd3;

  typedef struct packed {
    logic               start;
    logic [ModBits-1:0] dividend;
    logic [ModBits-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic                 done;
    logic [CoordBits-1:0] rem;
  } rem_resp_t;

endpackage

/* src/vspc_in_if.sv */
// Input sample channel: sync levels and color sample.
`timescale 1ns / 1ps

interface vspc_in_if;
  import vspc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 h_sync_in;
  logic                 v_sync_in;
  logic [ColorBits-1:0] red_in;
  logic [ColorBits-1:0] green_in;
  logic [ColorBits-1:0] blue_in;

  modport source (output valid, h_sync_in, v_sync_in, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, h_sync_in, v_sync_in, red_in, green_in, blue_in,
                  output ready);
endinterface

/* src/vspc_out_if.sv */
// Result channel: pixel write with coordinates and colors.
`timescale 1ns / 1ps

interface vspc_out_if;
  import vspc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] pixel_x;
  logic [CoordBits-1:0] pixel_y;
  logic [ColorBits-1:0] red_out;
  logic [ColorBits-1:0] green_out;
  logic [ColorBits-1:0] blue_out;

  modport source (output valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                  output ready);
endinterface

/* src/vspc_cfg_if.sv */
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface vspc_cfg_if;
  import vspc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/vspc_rem.sv */
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module vspc_rem (
  input  logic                clk,
  input  logic                rst_n,
  input  vspc_pkg::rem_req_t  req,
  output vspc_pkg::rem_resp_t resp
);
  import vspc_pkg::*;

  logic [ModBits-1:0]    rem_r, rem_nxt;
  logic [ModBits-1:0]    dvd_r;
  logic [ModBits-1:0]    dvs_r;
  logic [RemCntBits-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [ModBits:0]      trial;

  always_comb begin
    trial = {rem_r, dvd_r[ModBits-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = ModBits'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[ModBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= RemCntBits'(ModBits);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == RemCntBits'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[ModBits-2:0], 1'b0};
    end
  end

  // zero modulus wraps to zero
  assign resp.done = done_r;
  assign resp.rem  = (dvs_r == '0) ? '0 : rem_r[CoordBits-1:0];

endmodule

/* src/vga_sync_pixel_capture.sv */
// VGA sync pixel capture: beam position tracking and visible pixel write output.
//
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        h_sync_in, v_sync_in, red_in, green_in, blue_in
//  out_chan  out  valid/ready        pixel_x, pixel_y, red_out, green_out, blue_out
//  cfg_chan  in   valid/ready(=1)    index, data
//
// One sample per cycle while in_ready is high; a visible pixel appears in the output register the next cycle.
// Each config write starts a recompute of four modulo advance values in the shared
// bit-serial remainder unit, one value after another, with in_ready low throughout.
// Synchronous active-low reset loads the default 640x480 timing; no recompute follows it.
// in_ready falls only while the output register is full and stalled, during a recompute,
// or in a cycle with a config write.
`timescale 1ns / 1ps

module vga_sync_pixel_capture (
  input  logic       clk,
  input  logic       rst_n,
  vspc_in_if.sink    in_chan,
  vspc_out_if.source out_chan,
  vspc_cfg_if.sink   cfg_chan
);
  import vspc_pkg::*;

  // config registers
  logic [CoordBits-1:0] act_w_r, h_off_r, act_h_r, v_off_r;
  logic [ModBits-1:0]   tot_w_r, tot_h_r;

  // beam state; *_adv_r hold the count after the next advance
  logic [CoordBits-1:0] col_r, col_adv_r, h_rl_adv_r;
  logic [CoordBits-1:0] row_r, row_adv_r, v_rl_adv_r;
  logic                 last_h_r, last_v_r;

  logic                 out_valid_r;
  logic [CoordBits-1:0] px_r, py_r;
  logic [ColorBits-1:0] red_r, green_r, blue_r;

  logic                 recalc_r;
  logic [1:0]           job_r;
  logic                 start_r;

  rem_req_t             rem_req;
  rem_resp_t            rem_resp;

  logic                 cfg_fire, in_fire, h_fall, v_fall, emit;
  logic [CoordBits-1:0] h_reload, v_reload;
  logic [CoordBits-1:0] col_nxt, col_adv_nxt, row_mid, row_mid_adv, row_nxt, row_adv_nxt;
  logic [CoordBits-1:0] job_n;
  logic [ModBits-1:0]   job_m;

  // advance of a count already below the modulus
  function automatic logic [CoordBits-1:0] adv_small(input logic [CoordBits-1:0] c,
                                                     input logic [ModBits-1:0]   m);
    logic [ModBits-1:0] inc;
    inc = {1'b0, c} + 1'b1;
    if (m == '0 || inc == m) begin
      return '0;
    end
    return inc[CoordBits-1:0];
  endfunction

  assign h_reload = CoordBits'(tot_w_r - {1'b0, h_off_r});
  assign v_reload = CoordBits'(tot_h_r - {1'b0, v_off_r});

  assign cfg_fire       = cfg_chan.valid & cfg_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = ~recalc_r & ~cfg_chan.valid & (~out_valid_r | out_chan.ready);
  assign in_fire        = in_chan.valid & in_chan.ready;

  assign h_fall = last_h_r & ~in_chan.h_sync_in;
  assign v_fall = last_v_r & ~in_chan.v_sync_in;

  always_comb begin
    col_nxt     = h_fall ? h_reload : col_adv_r;
    col_adv_nxt = h_fall ? h_rl_adv_r : adv_small(col_adv_r, tot_w_r);
    row_mid     = h_fall ? row_adv_r : row_r;
    row_mid_adv = h_fall ? adv_small(row_adv_r, tot_h_r) : row_adv_r;
    row_nxt     = v_fall ? v_reload : row_mid;
    row_adv_nxt = v_fall ? v_rl_adv_r : row_mid_adv;
    emit        = (col_nxt < act_w_r) && (row_nxt < act_h_r);
  end

  // recompute job operands
  always_comb begin
    case (job_r)
      JobColAdv: begin
        job_n = col_r;
        job_m = tot_w_r;
      end
      JobHReloadAdv: begin
        job_n = h_reload;
        job_m = tot_w_r;
      end
      JobRowAdv: begin
        job_n = row_r;
        job_m = tot_h_r;
      end
      default: begin
        job_n = v_reload;
        job_m = tot_h_r;
      end
    endcase
  end

  assign rem_req.start    = start_r;
  assign rem_req.dividend = {1'b0, job_n} + 1'b1;
  assign rem_req.divisor  = job_m;

  vspc_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .resp  (rem_resp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_w_r <= CoordBits'(ActiveWidthReset);
      tot_w_r <= ModBits'(TotalWidthReset);
      h_off_r <= CoordBits'(HResyncOffsetReset);
      act_h_r <= CoordBits'(ActiveHeightReset);
      tot_h_r <= ModBits'(TotalHeightReset);
      v_off_r <= CoordBits'(VResyncOffsetReset);
    end else if (cfg_fire) begin
      case (cfg_chan.index)
        RegActiveWidth:   act_w_r <= cfg_chan.data[CoordBits-1:0];
        RegTotalWidth:    tot_w_r <= cfg_chan.data[ModBits-1:0];
        RegHResyncOffset: h_off_r <= cfg_chan.data[CoordBits-1:0];
        RegActiveHeight:  act_h_r <= cfg_chan.data[CoordBits-1:0];
        RegTotalHeight:   tot_h_r <= cfg_chan.data[ModBits-1:0];
        RegVResyncOffset: v_off_r <= cfg_chan.data[CoordBits-1:0];
        default: ;
      endcase
    end
  end

  // recompute sequencer; a new write restarts it from the first job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recalc_r <= 1'b0;
      job_r    <= JobColAdv;
      start_r  <= 1'b0;
    end else if (cfg_fire) begin
      recalc_r <= 1'b1;
      job_r    <= JobColAdv;
      start_r  <= 1'b1;
    end else if (recalc_r && rem_resp.done && !start_r) begin
      if (job_r == JobVReloadAdv) begin
        recalc_r <= 1'b0;
        start_r  <= 1'b0;
      end else begin
        job_r   <= job_r + 1'b1;
        start_r <= 1'b1;
      end
    end else begin
      start_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      col_adv_r  <= CoordBits'(ColAdvReset);
      row_adv_r  <= CoordBits'(RowAdvReset);
      h_rl_adv_r <= CoordBits'(HReloadAdvReset);
      v_rl_adv_r <= CoordBits'(VReloadAdvReset);
      last_h_r   <= 1'b0;
      last_v_r   <= 1'b0;
    end else if (in_fire) begin
      col_r     <= col_nxt;
      col_adv_r <= col_adv_nxt;
      row_r     <= row_nxt;
      row_adv_r <= row_adv_nxt;
      last_h_r  <= in_chan.h_sync_in;
      last_v_r  <= in_chan.v_sync_in;
    end else if (recalc_r && rem_resp.done && !start_r && !cfg_fire) begin
      case (job_r)
        JobColAdv:     col_adv_r  <= rem_resp.rem;
        JobHReloadAdv: h_rl_adv_r <= rem_resp.rem;
        JobRowAdv:     row_adv_r  <= rem_resp.rem;
        default:       v_rl_adv_r <= rem_resp.rem;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      px_r    <= col_nxt;
      py_r    <= row_nxt;
      red_r   <= in_chan.red_in;
      green_r <= in_chan.green_in;
      blue_r  <= in_chan.blue_in;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pixel_x   = px_r;
  assign out_chan.pixel_y   = py_r;
  assign out_chan.red_out   = red_r;
  assign out_chan.green_out = green_r;
  assign out_chan.blue_out  = blue_r;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the VGA sync pixel capture block.
`timescale 1ns / 1ps

module tb;
  import vspc_pkg::*;

  localparam int CycleLimit      = 400000;
  localparam int SettleCycles    = 8;
  localparam int LongHoldCycles  = 300;
  localparam int MaxIdle         = 17;
  localparam int RandPhases      = 6;
  localparam int PhaseItems      = 220;
  localparam int NoisePct        = 10;
  localparam logic [CfgIdxBits-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic                 h;
    logic                 v;
    logic [ColorBits-1:0] r;
    logic [ColorBits-1:0] g;
    logic [ColorBits-1:0] b;
  } sample_t;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [ColorBits-1:0] r;
    logic [ColorBits-1:0] g;
    logic [ColorBits-1:0] b;
  } pixel_t;

  typedef enum logic [1:0] {ChkModel, ChkPixel, ChkNone} row_check_t;

  typedef struct {
    bit                     is_cfg;
    logic [CfgIdxBits-1:0]  idx;
    logic [CfgDataBits-1:0] data;
    sample_t                s;
    row_check_t             chk;
    pixel_t                 pix;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  vspc_in_if  in_if ();
  vspc_out_if out_if ();
  vspc_cfg_if cfg_if ();

  vga_sync_pixel_capture uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #2 clk = ~clk;

  // beam tracker state and register copies
  logic [CoordBits-1:0] col_q;
  logic [CoordBits-1:0] row_q;
  logic                 last_h_q;
  logic                 last_v_q;
  logic [CoordBits-1:0] aw_q;
  logic [ModBits-1:0]   tw_q;
  logic [CoordBits-1:0] hoff_q;
  logic [CoordBits-1:0] ah_q;
  logic [ModBits-1:0]   th_q;
  logic [CoordBits-1:0] voff_q;

  pixel_t    pending_pixels[$];
  plan_row_t plan[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        idle_on = 1'b1;
  bit        hold_off_req = 1'b0;

  function automatic logic [CoordBits-1:0] wrap_advance(input logic [CoordBits-1:0] cnt,
                                                        input logic [ModBits-1:0] modulus);
    logic [ModBits-1:0] nxt;
    logic [ModBits-1:0] rem;
    nxt = {1'b0, cnt} + 1'b1;
    if (modulus == '0) return '0;
    rem = nxt % modulus;
    return rem[CoordBits-1:0];
  endfunction

  function automatic logic [CoordBits-1:0] resync_point(input logic [ModBits-1:0] total,
                                                        input logic [CoordBits-1:0] offset);
    logic [ModBits-1:0] diff;
    diff = total - {1'b0, offset};
    return diff[CoordBits-1:0];
  endfunction

  // advances the beam for one sample; returns 1 when the position is visible
  function automatic bit capture_pixel(input sample_t s, output pixel_t p);
    col_q = wrap_advance(col_q, tw_q);
    if (!s.h && last_h_q) begin
      col_q = resync_point(tw_q, hoff_q);
      row_q = wrap_advance(row_q, th_q);
    end
    // vertical reload wins over the row advance when both fall
    if (!s.v && last_v_q) row_q = resync_point(th_q, voff_q);
    last_h_q = s.h;
    last_v_q = s.v;
    p.x = col_q;
    p.y = row_q;
    p.r = s.r;
    p.g = s.g;
    p.b = s.b;
    return (col_q < aw_q) && (row_q < ah_q);
  endfunction

  function automatic void add_item(input logic h, input logic v,
                                   input logic [ColorBits-1:0] r, input logic [ColorBits-1:0] g,
                                   input logic [ColorBits-1:0] b, input row_check_t chk,
                                   input int x, input int y);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = '0;
    row.data   = '0;
    row.s.h    = h;
    row.s.v    = v;
    row.s.r    = r;
    row.s.g    = g;
    row.s.b    = b;
    row.chk    = chk;
    row.pix.x  = CoordBits'(x);
    row.pix.y  = CoordBits'(y);
    row.pix.r  = r;
    row.pix.g  = g;
    row.pix.b  = b;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CfgIdxBits-1:0] idx,
                                  input logic [CfgDataBits-1:0] data);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    row.s      = '0;
    row.chk    = ChkNone;
    row.pix    = '0;
    plan.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] expv,
                                      input logic [15:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
      mismatch_count++;
    end
  endfunction

  task automatic send_item(input sample_t s);
    int gap;
    gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.h_sync_in <= s.h;
    in_if.v_sync_in <= s.v;
    in_if.red_in    <= s.r;
    in_if.green_in  <= s.g;
    in_if.blue_in   <= s.b;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // leaves cfg valid high; the caller lowers it after the last write of a batch
  task automatic cfg_write(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      RegActiveWidth:   aw_q   = val[CoordBits-1:0];
      RegTotalWidth:    tw_q   = val;
      RegHResyncOffset: hoff_q = val[CoordBits-1:0];
      RegActiveHeight:  ah_q   = val[CoordBits-1:0];
      RegTotalHeight:   th_q   = val;
      RegVResyncOffset: voff_q = val[CoordBits-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // result side: random stall per item, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (hold_off_req && !hold_done) begin
        stall = LongHoldCycles;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel write, expected none, got x=%0d y=%0d", $time,
                 out_if.pixel_x, out_if.pixel_y);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", 16'(want.x), 16'(out_if.pixel_x));
        check_field("pixel_y", 16'(want.y), 16'(out_if.pixel_y));
        check_field("red_out", 16'(want.r), 16'(out_if.red_out));
        check_field("green_out", 16'(want.g), 16'(out_if.green_out));
        check_field("blue_out", 16'(want.b), 16'(out_if.blue_out));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    sample_t              s;
    pixel_t               pix;
    bit                   produced;
    logic [ModBits-1:0]   tw;
    logic [ModBits-1:0]   th;
    logic [CoordBits-1:0] aw;
    logic [CoordBits-1:0] ah;
    logic [CoordBits-1:0] hoff;
    logic [CoordBits-1:0] voff;
    int                   base_len;
    int                   line_len;
    int                   hs_w;
    int                   frame_lines;
    int                   vs_w;
    int                   pos;
    int                   line_no;

    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.h_sync_in <= 1'b0;
    in_if.v_sync_in <= 1'b0;
    in_if.red_in    <= '0;
    in_if.green_in  <= '0;
    in_if.blue_in   <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;

    col_q    = '0;
    row_q    = '0;
    last_h_q = 1'b0;
    last_v_q = 1'b0;
    aw_q     = CoordBits'(ActiveWidthReset);
    tw_q     = ModBits'(TotalWidthReset);
    hoff_q   = CoordBits'(HResyncOffsetReset);
    ah_q     = CoordBits'(ActiveHeightReset);
    th_q     = ModBits'(TotalHeightReset);
    voff_q   = CoordBits'(VResyncOffsetReset);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default 640x480 timing straight out of reset
    add_item(1'b0, 1'b0, 4'h0, 4'h0, 4'h0, ChkPixel, 1, 0);
    add_item(1'b1, 1'b1, 4'hF, 4'hF, 4'hF, ChkPixel, 2, 0);
    add_item(1'b0, 1'b1, 4'h6, 4'h9, 4'hC, ChkNone, 0, 0);
    add_item(1'b1, 1'b0, 4'h3, 4'h3, 4'h3, ChkNone, 0, 0);
    add_item(1'b0, 1'b1, 4'h1, 4'h2, 4'h4, ChkModel, 0, 0);
    add_item(1'b1, 1'b1, 4'h5, 4'hA, 4'h3, ChkModel, 0, 0);
    // both syncs fall together
    add_item(1'b0, 1'b0, 4'h8, 4'h4, 4'h2, ChkModel, 0, 0);
    // zero width modulus, then a resync with offset above the total
    add_cfg(RegTotalWidth, 11'd0);
    add_cfg(RegActiveHeight, 11'd1023);
    add_item(1'b1, 1'b1, 4'h1, 4'h2, 4'h3, ChkPixel, 0, 490);
    add_item(1'b0, 1'b1, 4'h7, 4'h8, 4'h9, ChkModel, 0, 0);
    // counter already past a small modulus
    add_cfg(RegTotalWidth, 11'd5);
    add_item(1'b1, 1'b1, 4'hE, 4'hD, 4'hB, ChkModel, 0, 0);
    add_item(1'b0, 1'b0, 4'h7, 4'hB, 4'hD, ChkModel, 0, 0);
    // writes to indexes past the register list change nothing
    add_cfg(RegSpareLo, 11'd0);
    add_cfg(RegSpareHi, 11'h7FF);
    add_item(1'b1, 1'b1, 4'hA, 4'h5, 4'hF, ChkModel, 0, 0);
    // largest settings; bit 10 of the narrow registers is dropped
    add_cfg(RegTotalWidth, 11'd2047);
    add_cfg(RegActiveWidth, 11'h7FF);
    add_cfg(RegHResyncOffset, 11'h7FF);
    add_cfg(RegVResyncOffset, 11'd0);
    add_cfg(RegTotalHeight, 11'd1024);
    add_cfg(RegActiveHeight, 11'd1023);
    add_item(1'b1, 1'b1, 4'h0, 4'hF, 4'h0, ChkModel, 0, 0);
    add_item(1'b0, 1'b1, 4'hF, 4'h0, 4'hF, ChkModel, 0, 0);
    add_item(1'b1, 1'b0, 4'h9, 4'h6, 4'h1, ChkModel, 0, 0);
    add_item(1'b0, 1'b0, 4'h2, 4'hE, 4'h7, ChkModel, 0, 0);
    add_item(1'b1, 1'b1, 4'hC, 4'h1, 4'h8, ChkModel, 0, 0);
    // smallest settings
    add_cfg(RegActiveWidth, 11'd1);
    add_cfg(RegActiveHeight, 11'd1);
    add_cfg(RegTotalWidth, 11'd1);
    add_cfg(RegTotalHeight, 11'd1);
    add_cfg(RegHResyncOffset, 11'd0);
    add_cfg(RegVResyncOffset, 11'd0);
    add_item(1'b1, 1'b1, 4'h4, 4'h8, 4'h1, ChkModel, 0, 0);
    add_item(1'b0, 1'b1, 4'hB, 4'h7, 4'hE, ChkModel, 0, 0);
    add_item(1'b1, 1'b0, 4'hD, 4'h3, 4'h6, ChkModel, 0, 0);
    add_item(1'b0, 1'b0, 4'h5, 4'hC, 4'hA, ChkModel, 0, 0);
    add_item(1'b1, 1'b1, 4'hF, 4'hF, 4'h0, ChkModel, 0, 0);

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) wait_idle();
        cfg_write(plan[i].idx, plan[i].data);
        if (i + 1 == plan.size() || !plan[i+1].is_cfg) cfg_if.valid <= 1'b0;
      end else begin
        send_item(plan[i].s);
        produced = capture_pixel(plan[i].s, pix);
        case (plan[i].chk)
          ChkModel: if (produced) pending_pixels.push_back(pix);
          ChkPixel: pending_pixels.push_back(plan[i].pix);
          default: ;
        endcase
      end
    end

    // random frames of small timings, then one phase with totals of 1024, with random content and some noise
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph == RandPhases - 1) begin
        tw = 11'd1024;
        th = 11'd1024;
        aw = 10'd1023;
        ah = 10'd1023;
        hoff = CoordBits'($urandom_range(0, 1023));
        voff = CoordBits'($urandom_range(0, 1023));
        base_len = 40;
        frame_lines = 6;
      end else begin
        tw = ModBits'($urandom_range(8, 40));
        th = ModBits'($urandom_range(3, 12));
        aw = CoordBits'($urandom_range(1, tw + 2));
        ah = CoordBits'($urandom_range(1, th + 1));
        hoff = CoordBits'($urandom_range(0, tw + 2));
        voff = CoordBits'($urandom_range(0, th + 1));
        base_len = tw + $urandom_range(0, 4) - 2;
        frame_lines = th + $urandom_range(0, 2) - 1;
      end
      hs_w = $urandom_range(1, 4);
      vs_w = $urandom_range(1, 2);

      wait_idle();
      cfg_write(RegTotalWidth, tw);
      cfg_write(RegActiveWidth, CfgDataBits'(aw));
      cfg_write(RegHResyncOffset, CfgDataBits'(hoff));
      cfg_write(RegTotalHeight, th);
      cfg_write(RegActiveHeight, CfgDataBits'(ah));
      cfg_write(RegVResyncOffset, CfgDataBits'(voff));
      if ($urandom_range(0, 1)) begin
        cfg_write($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, CfgDataBits'($urandom));
      end
      cfg_if.valid <= 1'b0;

      idle_on = !(ph == 1 || ph == 2);
      if (ph == 2) hold_off_req = 1'b1;

      pos = 0;
      line_no = 0;
      line_len = base_len;
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < NoisePct) begin
          s.h = 1'($urandom_range(0, 1));
          s.v = 1'($urandom_range(0, 1));
        end else begin
          // syncs are active low: the pulse opens each line and each frame
          s.h = (pos >= hs_w);
          s.v = (line_no >= vs_w);
        end
        s.r = ColorBits'($urandom_range(0, 15));
        s.g = ColorBits'($urandom_range(0, 15));
        s.b = ColorBits'($urandom_range(0, 15));
        pos++;
        if (pos >= line_len) begin
          pos = 0;
          line_no = (line_no + 1 >= frame_lines) ? 0 : line_no + 1;
          line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 2 * base_len) : base_len;
        end
        send_item(s);
        if (capture_pixel(s, pix)) pending_pixels.push_back(pix);
      end
    end

    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
src/vspc_pkg.sv
src/vspc_in_if.sv
src/vspc_out_if.sv
src/vspc_cfg_if.sv
src/vspc_rem.sv
src/vga_sync_pixel_capture.sv
tb/tb.sv
